// File: rtl/alarm_melody_sequencer_unit_defines.svh
// Assertion macros for the alarm melody sequencer unit.
// Included by the top level; expects clk and rst_n in the including scope.
`ifndef ALARM_MELODY_SEQUENCER_UNIT_DEFINES_SVH
`define ALARM_MELODY_SEQUENCER_UNIT_DEFINES_SVH
`ifndef SYNTH
// Implication checked in the same cycle.
`define AMSU_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("alarm melody sequencer: check failed");
// Implication checked in the following cycle.
`define AMSU_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("alarm melody sequencer: check failed");
`else
`define AMSU_ASSERT_NOW(label, pre, post)
`define AMSU_ASSERT_NEXT(label, pre, post)
`endif
`endif

// File: rtl/amsu_pkg.sv
// Package for the alarm melody sequencer: item kinds, register indexes,
// play state type, character constants and the note frequency table.
`default_nettype none

package amsu_pkg;

  localparam int unsigned TEMPO_W = 16;
  localparam int unsigned TONE_W  = 10;
  localparam int unsigned WAIT_W  = 4;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned IDX_W   = 6;

  localparam logic [TEMPO_W-1:0] TICK_MAX     = '1;
  localparam logic [TEMPO_W-1:0] TEMPO_RESET  = 16'd100;
  localparam logic [BYTE_W-1:0]  CHAR_ZERO    = 8'h30;
  localparam logic [BYTE_W-1:0]  CHAR_NINE    = 8'h39;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_START = 2'd2,
    KIND_STOP  = 2'd3
  } kind_t;

  typedef enum logic [0:0] {
    CFG_TEMPO_MS = 1'b0,
    CFG_ONE_SHOT = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic                running;
    logic [TONE_W-1:0]   tone;
    logic [WAIT_W-1:0]   wait_cnt;
    logic [TEMPO_W-1:0]  tick_cnt;
  } play_state_t;

  // Note character to tone frequency; the rest and anything unknown are silent.
  function automatic logic [TONE_W-1:0] note_hz(input logic [BYTE_W-1:0] ch);
    logic [TONE_W-1:0] hz;
    case (ch)
      8'h43:   hz = 10'd262;  // C
      8'h63:   hz = 10'd277;  // c
      8'h44:   hz = 10'd294;  // D
      8'h64:   hz = 10'd311;  // d
      8'h45:   hz = 10'd330;  // E
      8'h46:   hz = 10'd349;  // F
      8'h66:   hz = 10'd370;  // f
      8'h47:   hz = 10'd392;  // G
      8'h67:   hz = 10'd415;  // g
      8'h41:   hz = 10'd440;  // A
      8'h61:   hz = 10'd466;  // a
      8'h42:   hz = 10'd494;  // B
      8'h55:   hz = 10'd524;  // U
      8'h75:   hz = 10'd554;  // u
      8'h56:   hz = 10'd587;  // V
      8'h76:   hz = 10'd622;  // v
      8'h57:   hz = 10'd659;  // W
      8'h77:   hz = 10'd698;  // w
      8'h59:   hz = 10'd740;  // Y
      8'h79:   hz = 10'd784;  // y
      8'h5A:   hz = 10'd831;  // Z
      8'h7A:   hz = 10'd880;  // z
      8'h48:   hz = 10'd932;  // H
      8'h68:   hz = 10'd988;  // h
      default: hz = '0;
    endcase
    return hz;
  endfunction

endpackage

`default_nettype wire

// File: rtl/amsu_ram.sv
// Melody store bank: one write port, one registered read port, write-first.
// Depends on nothing else; instantiated by the top level.
`default_nettype none

module amsu_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned DW    = 8,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  // A write to the address being read is passed straight to the read register.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (we && (waddr == raddr)) begin
      rdata_r <= wdata;
    end else begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// File: rtl/amsu_step.sv
// Next-state logic for one item of the alarm melody sequencer.
// Depends on amsu_pkg; instantiated by the top level.
`default_nettype none

module amsu_step #(
  parameter int unsigned MELODY_DEPTH = 64,
  localparam int unsigned AW          = $clog2(MELODY_DEPTH)
) (
  input  logic                                 item_valid,
  input  amsu_pkg::kind_t                      item_kind,
  input  logic [amsu_pkg::TEMPO_W-1:0]         tempo_ms,
  input  logic                                 one_shot,
  input  amsu_pkg::play_state_t                st,
  input  logic [AW-1:0]                        pos,
  input  logic [amsu_pkg::BYTE_W-1:0]          rd_dur,
  input  logic [amsu_pkg::BYTE_W-1:0]          rd_note,
  input  logic [amsu_pkg::BYTE_W-1:0]          rd_end,
  output amsu_pkg::play_state_t                st_nxt,
  output logic [AW-1:0]                        pos_nxt,
  output logic                                 stepped,
  output logic [AW-1:0]                        addr_dur,
  output logic [AW-1:0]                        addr_note,
  output logic [AW-1:0]                        addr_end
);

  import amsu_pkg::*;

  localparam int unsigned SW = AW + 1;
  localparam logic [SW-1:0] DEPTH_S = SW'(MELODY_DEPTH);

  logic [TEMPO_W-1:0] tick_inc;
  logic [BYTE_W-1:0]  dur_diff;
  logic [WAIT_W-1:0]  dur_val;
  logic               end_hit;
  logic [AW-1:0]      pos_p2;

  // Position plus a small step, wrapped into the store.
  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] p, input logic [1:0] k);
    logic [SW-1:0] s;
    s = {1'b0, p} + {{(SW-2){1'b0}}, k};
    if (s >= DEPTH_S) begin
      s = s - DEPTH_S;
    end
    return s[AW-1:0];
  endfunction

  assign dur_diff = rd_dur - CHAR_ZERO;
  assign dur_val  = (rd_dur inside {[CHAR_ZERO:CHAR_NINE]}) ? dur_diff[WAIT_W-1:0] : '0;
  assign end_hit  = (rd_end == CHAR_ZERO);
  assign pos_p2   = wrap_add(pos, 2'd2);
  assign tick_inc = (st.tick_cnt == TICK_MAX) ? st.tick_cnt : st.tick_cnt + 16'd1;

  always_comb begin
    st_nxt  = st;
    pos_nxt = pos;
    stepped = 1'b0;
    if (item_valid) begin
      case (item_kind)
        KIND_TICK: begin
          st_nxt.tick_cnt = tick_inc;
          if (tick_inc >= tempo_ms) begin
            stepped         = 1'b1;
            st_nxt.tick_cnt = '0;
            if (!st.running || ((st.wait_cnt == '0) && end_hit && one_shot)) begin
              st_nxt.running  = 1'b0;
              st_nxt.tone     = '0;
              st_nxt.wait_cnt = '0;
              pos_nxt         = '0;
            end else if (st.wait_cnt != '0) begin
              st_nxt.wait_cnt = st.wait_cnt - 4'd1;
            end else begin
              st_nxt.wait_cnt = dur_val;
              st_nxt.tone     = note_hz(rd_note);
              pos_nxt         = end_hit ? '0 : pos_p2;
            end
          end
        end
        KIND_WRITE: begin
        end
        KIND_START: begin
          st_nxt.running = 1'b1;
        end
        KIND_STOP: begin
          st_nxt.running = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // The store banks are read at the position that holds after this item.
  assign addr_dur  = pos_nxt;
  assign addr_note = wrap_add(pos_nxt, 2'd1);
  assign addr_end  = wrap_add(pos_nxt, 2'd2);

endmodule

`default_nettype wire

// File: rtl/alarm_melody_sequencer_unit.sv
// Top level of the alarm melody sequencer: input register, play state,
// configuration registers and melody store. Depends on amsu_pkg, amsu_ram, amsu_step.
`default_nettype none
`include "alarm_melody_sequencer_unit_defines.svh"

// Channel   | Handshake          | Word
// ----------+--------------------+------------------------------------------
// input     | start / busy       | in_kind, in_store_index, in_store_byte
// result    | out_valid strobe   | out_tone_hz, out_playing, out_stepped
// config    | cfg_we             | cfg_index, cfg_wdata
//
// One word is taken in every cycle; busy never rises. A word is first captured in
// the input register; its result is then registered into the play state and the
// result strobe. Three copies of the melody store are read each cycle at the play
// position and the two entries after it, with registered read data. Reset is
// synchronous and active low and clears the play state, the tick count and the
// one-shot flag and loads the reset tempo; the store keeps its contents and needs
// no clearing pass.
// The receiver cannot stall: each result is on the ports for exactly one cycle.

module alarm_melody_sequencer_unit #(
  parameter int unsigned MELODY_DEPTH = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         in_kind,
  input  logic [amsu_pkg::IDX_W-1:0]         in_store_index,
  input  logic [amsu_pkg::BYTE_W-1:0]        in_store_byte,
  output logic                               out_valid,
  output logic [amsu_pkg::TONE_W-1:0]        out_tone_hz,
  output logic                               out_playing,
  output logic                               out_stepped,
  input  logic                               cfg_we,
  input  logic [0:0]                         cfg_index,
  input  logic [amsu_pkg::TEMPO_W-1:0]       cfg_wdata
);

  import amsu_pkg::*;

  localparam int unsigned AW      = $clog2(MELODY_DEPTH);
  localparam int unsigned SW      = AW + 1;
  localparam int unsigned IDX_CNT = 1 << IDX_W;
  localparam logic [SW-1:0] DEPTH_S = SW'(MELODY_DEPTH);

  // Input register: the word accepted at the last edge.
  logic                in_valid_r;
  kind_t               kind_r;
  logic [IDX_W-1:0]    idx_r;
  logic [BYTE_W-1:0]   byte_r;

  // Configuration registers.
  logic [TEMPO_W-1:0]  tempo_r;
  logic                one_shot_r;

  // Play state and result strobe.
  play_state_t         st_r;
  play_state_t         st_nxt;
  logic [AW-1:0]       pos_r;
  logic [AW-1:0]       pos_nxt;
  logic                stepped;
  logic                stepped_r;
  logic                out_valid_r;

  // Store access.
  logic [AW-1:0]       addr_dur;
  logic [AW-1:0]       addr_note;
  logic [AW-1:0]       addr_end;
  logic [BYTE_W-1:0]   rd_dur;
  logic [BYTE_W-1:0]   rd_note;
  logic [BYTE_W-1:0]   rd_end;
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [AW-1:0]       wrap_tbl [IDX_CNT];

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      kind_r <= kind_t'(in_kind);
      idx_r  <= in_store_index;
      byte_r <= in_store_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tempo_r    <= TEMPO_RESET;
      one_shot_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_TEMPO_MS: begin
          tempo_r <= cfg_wdata;
        end
        CFG_ONE_SHOT: begin
          one_shot_r <= cfg_wdata[0];
        end
        default: begin
        end
      endcase
    end
  end

  // Store address of a write word, wrapped into the store; a constant table
  // built at elaboration, since the write index is only six bits wide.
  for (genvar g = 0; g < IDX_CNT; g++) begin : g_wrap
    assign wrap_tbl[g] = AW'(g % MELODY_DEPTH);
  end

  assign ram_we    = in_valid_r && (kind_r == KIND_WRITE);
  assign ram_waddr = wrap_tbl[idx_r];

  // Three identical copies of the store, one for each entry that a step reads:
  // the duration digit, the note and the byte that may mark the melody end.
  amsu_ram #(
    .DEPTH (MELODY_DEPTH),
    .DW    (BYTE_W)
  ) u_ram_dur (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (byte_r),
    .raddr (addr_dur),
    .rdata (rd_dur)
  );

  amsu_ram #(
    .DEPTH (MELODY_DEPTH),
    .DW    (BYTE_W)
  ) u_ram_note (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (byte_r),
    .raddr (addr_note),
    .rdata (rd_note)
  );

  amsu_ram #(
    .DEPTH (MELODY_DEPTH),
    .DW    (BYTE_W)
  ) u_ram_end (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (byte_r),
    .raddr (addr_end),
    .rdata (rd_end)
  );

  // All the work for the word in the input register happens here, combinationally.
  amsu_step #(
    .MELODY_DEPTH (MELODY_DEPTH)
  ) u_step (
    .item_valid (in_valid_r),
    .item_kind  (kind_r),
    .tempo_ms   (tempo_r),
    .one_shot   (one_shot_r),
    .st         (st_r),
    .pos        (pos_r),
    .rd_dur     (rd_dur),
    .rd_note    (rd_note),
    .rd_end     (rd_end),
    .st_nxt     (st_nxt),
    .pos_nxt    (pos_nxt),
    .stepped    (stepped),
    .addr_dur   (addr_dur),
    .addr_note  (addr_note),
    .addr_end   (addr_end)
  );

  // The play state doubles as the result register for the tone and run flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
      stepped_r   <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= in_valid_r;
      stepped_r   <= stepped;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_tone_hz = st_r.tone;
  assign out_playing = st_r.running;
  assign out_stepped = stepped_r;

  // Each result strobe follows a taken word through the input and result registers.
  `AMSU_ASSERT_NOW(a_result_follows_word, out_valid, $past(start && !busy, 2))
  // A completed period that leaves the melody stopped must leave it silent.
  `AMSU_ASSERT_NOW(a_stopped_is_silent, out_valid && out_stepped && !out_playing, out_tone_hz == '0)
  // The wait count moves only on tick words.
  `AMSU_ASSERT_NEXT(a_wait_only_on_tick, !(in_valid_r && (kind_r == KIND_TICK)), $stable(st_r.wait_cnt))
  // The play position always lies inside the store.
  `AMSU_ASSERT_NOW(a_pos_in_store, 1'b1, {1'b0, pos_r} < DEPTH_S)

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the alarm melody sequencer unit: directed tests, then
// randomised phases, with every result word compared against an in-bench melody player.
// Depends on amsu_pkg and the alarm_melody_sequencer_unit RTL.

module tb_top;
  import amsu_pkg::*;

  localparam int unsigned DEPTH       = 64;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  // The block answers through its input register and result register; SETTLE adds margin.
  localparam int unsigned SETTLE      = 6;

  // One expected result word: tone, running flag and the period-end strobe.
  typedef struct packed {
    logic [TONE_W-1:0] tone;
    logic              playing;
    logic              stepped;
  } chime_t;

  logic                clk            = 1'b0;
  logic                rst_n          = 1'b0;
  logic                start          = 1'b0;
  logic                busy;
  logic [1:0]          in_kind        = KIND_TICK;
  logic [IDX_W-1:0]    in_store_index = '0;
  logic [BYTE_W-1:0]   in_store_byte  = '0;
  logic                out_valid;
  logic [TONE_W-1:0]   out_tone_hz;
  logic                out_playing;
  logic                out_stepped;
  logic                cfg_we         = 1'b0;
  logic [0:0]          cfg_index      = CFG_TEMPO_MS;
  logic [TEMPO_W-1:0]  cfg_wdata      = '0;

  // The testbench's own copy of the player: store, position, wait count, tick
  // count, running flag, tone and the two configuration registers.
  logic [BYTE_W-1:0]   tune [DEPTH];
  logic [IDX_W-1:0]    cursor      = '0;
  logic [WAIT_W-1:0]   hold        = '0;
  logic [TEMPO_W-1:0]  ms_count    = '0;
  logic                sounding    = 1'b0;
  logic [TONE_W-1:0]   pitch       = '0;
  logic [TEMPO_W-1:0]  period_ms   = TEMPO_RESET;
  logic                single_pass = 1'b0;

  chime_t      expected_chimes [$];
  int          fails  = 0;
  int unsigned cycles = 0;
  bit          burst  = 1'b0;

  // Every note character of the table, with the rest last.
  string note_chars = "CcDdEFfGgAaBUuVvWwYyZzHhX";

  alarm_melody_sequencer_unit #(
    .MELODY_DEPTH(DEPTH)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_kind       (in_kind),
    .in_store_index(in_store_index),
    .in_store_byte (in_store_byte),
    .out_valid     (out_valid),
    .out_tone_hz   (out_tone_hz),
    .out_playing   (out_playing),
    .out_stepped   (out_stepped),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Melody player prediction
  // ---------------------------------------------------------------------------

  function automatic logic [TONE_W-1:0] pitch_of(input logic [BYTE_W-1:0] ch);
    case (ch)
      "C":     return 10'd262;
      "c":     return 10'd277;
      "D":     return 10'd294;
      "d":     return 10'd311;
      "E":     return 10'd330;
      "F":     return 10'd349;
      "f":     return 10'd370;
      "G":     return 10'd392;
      "g":     return 10'd415;
      "A":     return 10'd440;
      "a":     return 10'd466;
      "B":     return 10'd494;
      "U":     return 10'd524;
      "u":     return 10'd554;
      "V":     return 10'd587;
      "v":     return 10'd622;
      "W":     return 10'd659;
      "w":     return 10'd698;
      "Y":     return 10'd740;
      "y":     return 10'd784;
      "Z":     return 10'd831;
      "z":     return 10'd880;
      "H":     return 10'd932;
      "h":     return 10'd988;
      default: return '0;
    endcase
  endfunction

  function void silence();
    cursor   = '0;
    hold     = '0;
    pitch    = '0;
    sounding = 1'b0;
  endfunction

  // One tempo period of a running melody: either load the next pair or count the
  // wait down. The byte after the pair decides whether the melody has ended.
  function void step_melody();
    logic [BYTE_W-1:0] dur;
    logic [IDX_W-1:0]  note_at;
    if (hold == '0) begin
      dur     = tune[cursor];
      note_at = cursor + IDX_W'(1);
      hold    = (dur >= CHAR_ZERO && dur <= CHAR_NINE) ? WAIT_W'(dur - CHAR_ZERO) : '0;
      pitch   = pitch_of(tune[note_at]);
      cursor  = cursor + IDX_W'(2);
      if (tune[cursor] == CHAR_ZERO) begin
        if (single_pass) silence();
        else cursor = '0;
      end
    end else begin
      hold = hold - WAIT_W'(1);
    end
  endfunction

  function chime_t next_chime(input logic [1:0] kind, input logic [IDX_W-1:0] idx,
                              input logic [BYTE_W-1:0] data);
    chime_t c;
    c.stepped = 1'b0;
    case (kind)
      KIND_TICK: begin
        if (ms_count != TICK_MAX) ms_count = ms_count + TEMPO_W'(1);
        if (ms_count >= period_ms) begin
          c.stepped = 1'b1;
          ms_count  = '0;
          if (sounding) step_melody();
          else silence();
        end
      end
      KIND_WRITE: tune[idx] = data;
      KIND_START: sounding = 1'b1;
      default:    sounding = 1'b0;
    endcase
    c.tone    = pitch;
    c.playing = sounding;
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitors
  // ---------------------------------------------------------------------------

  // A word is taken at a rising edge with start high and busy low. Inputs change
  // only at the falling edge, and the block's outputs settle after its nonblocking
  // updates, so sampling here sees the values from before the edge.
  always @(posedge clk) begin
    if (rst_n && start && !busy)
      expected_chimes.push_back(next_chime(in_kind, in_store_index, in_store_byte));
  end

  always @(posedge clk) begin : check_words
    chime_t want;
    if (rst_n && out_valid) begin
      if (expected_chimes.size() == 0) begin
        $error("result word with no prediction waiting: tone_hz %0d playing %0b stepped %0b",
               out_tone_hz, out_playing, out_stepped);
        fails++;
      end else begin
        want = expected_chimes.pop_front();
        if (out_tone_hz !== want.tone) begin
          $error("tone_hz: expected %0d, actual %0d", want.tone, out_tone_hz);
          fails++;
        end
        if (out_playing !== want.playing) begin
          $error("playing: expected %0b, actual %0b", want.playing, out_playing);
          fails++;
        end
        if (out_stepped !== want.stepped) begin
          $error("stepped: expected %0b, actual %0b", want.stepped, out_stepped);
          fails++;
        end
      end
    end
  end

  // A hung block must not leave the run hanging with it.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  function automatic int unsigned pick_gap();
    if (burst) return 0;
    return $urandom_range(0, 17);
  endfunction

  // Sends one input word after a gap of idle cycles and returns once it is taken.
  // Start is only ever written once per falling edge, so a word that follows
  // straight on keeps start high without a glitch.
  task automatic send_word(input kind_t kind, input logic [IDX_W-1:0] idx,
                           input logic [BYTE_W-1:0] data, input int unsigned gap);
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start          <= 1'b1;
    in_kind        <= kind;
    in_store_index <= idx;
    in_store_byte  <= data;
    do @(posedge clk); while (busy);
  endtask

  // Millisecond ticks; the unused fields carry random bits so that they toggle.
  task automatic tick_run(input int unsigned n, input bit no_gaps);
    repeat (n) send_word(KIND_TICK, IDX_W'($urandom), BYTE_W'($urandom),
                         no_gaps ? 0 : pick_gap());
  endtask

  // Holds the sender off until every predicted word has come back, then lets the
  // pipeline run dry.
  task automatic wait_quiet();
    @(negedge clk);
    start <= 1'b0;
    while (expected_chimes.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Registers are only written with the block idle, so the prediction can take
  // the new value at once.
  task automatic write_reg(input cfg_idx_t idx, input logic [TEMPO_W-1:0] value);
    wait_quiet();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    if (idx == CFG_TEMPO_MS) period_ms = value;
    else single_pass = value[0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Out of reset the tempo is 100 ticks: the hundredth tick ends the first period.
  // Nothing is playing yet, so that period only silences and rewinds.
  task automatic test_reset_tempo();
    send_word(KIND_STOP, IDX_W'($urandom), BYTE_W'($urandom), pick_gap());
    tick_run(100, 1'b0);
    send_word(KIND_START, IDX_W'($urandom), BYTE_W'($urandom), pick_gap());
    send_word(KIND_STOP, IDX_W'($urandom), BYTE_W'($urandom), pick_gap());
    tick_run(3, 1'b0);
  endtask

  // Fills the whole store before anything can read it. Every note of the table,
  // the rest and several unknown characters are used, with durations that include
  // the longest digit and bytes that are not digits at all. There is no end
  // marker yet, so the melody runs through the last pair and wraps to the first.
  task automatic test_load_melody();
    string             odd_notes;
    logic [BYTE_W-1:0] dur;
    logic [BYTE_W-1:0] note;
    odd_notes = {note_chars, "?bxI0q"};
    for (int k = 0; k < DEPTH / 2; k++) begin
      case (k)
        0:       dur = "9";
        1:       dur = "q";
        2:       dur = 8'hB5;
        3:       dur = "/";
        4:       dur = ":";
        default: dur = (k % 3 == 0) ? "2" : "1";
      endcase
      note = (k < odd_notes.len()) ? odd_notes.getc(k) : 8'hC3;
      send_word(KIND_WRITE, IDX_W'(2 * k), dur, pick_gap());
      send_word(KIND_WRITE, IDX_W'(2 * k + 1), note, pick_gap());
    end
  endtask

  // Looping play at the fastest sensible tempo, through the wrap of the store
  // index, with a second start while running that must change nothing.
  task automatic test_loop_play();
    write_reg(CFG_TEMPO_MS, 16'd1);
    write_reg(CFG_ONE_SHOT, 16'hFFFE);
    send_word(KIND_START, IDX_W'($urandom), BYTE_W'($urandom), pick_gap());
    tick_run(170, 1'b0);
    send_word(KIND_START, IDX_W'($urandom), BYTE_W'($urandom), pick_gap());
    tick_run(5, 1'b0);
  endtask

  // An end marker part way through: looping returns to the first pair, one-shot
  // stops and silences the tone within the same period.
  task automatic test_end_marker();
    send_word(KIND_WRITE, IDX_W'(52), CHAR_ZERO, pick_gap());
    tick_run(150, 1'b0);
    write_reg(CFG_ONE_SHOT, 16'h0001);
    send_word(KIND_START, IDX_W'($urandom), BYTE_W'($urandom), pick_gap());
    tick_run(150, 1'b0);
  endtask

  // A stop only clears the running flag; the tone stays until the next period end.
  task automatic test_stop_mid_melody();
    write_reg(CFG_ONE_SHOT, 16'h0000);
    write_reg(CFG_TEMPO_MS, 16'd3);
    send_word(KIND_START, IDX_W'($urandom), BYTE_W'($urandom), pick_gap());
    tick_run(40, 1'b0);
    send_word(KIND_STOP, IDX_W'($urandom), BYTE_W'($urandom), pick_gap());
    tick_run(4, 1'b0);
    send_word(KIND_START, IDX_W'($urandom), BYTE_W'($urandom), pick_gap());
    tick_run(12, 1'b0);
  endtask

  // Tempo zero steps on every tick. The largest tempo holds the period open through
  // every tick of its run. Lowering the tempo below a count already reached ends the
  // period on the very next tick.
  task automatic test_tempo_extremes();
    write_reg(CFG_TEMPO_MS, 16'd0);
    tick_run(30, 1'b0);
    write_reg(CFG_TEMPO_MS, 16'hFFFF);
    tick_run(300, 1'b0);
    write_reg(CFG_TEMPO_MS, 16'd5);
    tick_run(3, 1'b0);
  endtask

  // Random phases, each with its own tempo and end mode. Most writes keep the
  // pair layout (digit at even addresses, note at odd ones) so that the melody
  // keeps playing; the rest are noise. Bursts without gaps come and go at random.
  task automatic test_random_phases();
    int unsigned       pick;
    int unsigned       r;
    logic [IDX_W-1:0]  idx;
    logic [BYTE_W-1:0] data;
    logic [TEMPO_W-1:0] mode;
    for (int p = 0; p < 8; p++) begin
      case (p)
        1:       write_reg(CFG_TEMPO_MS, 16'd0);
        2:       write_reg(CFG_TEMPO_MS, 16'd2);
        3:       write_reg(CFG_TEMPO_MS, TEMPO_W'($urandom_range(1, 4)));
        4:       write_reg(CFG_TEMPO_MS, 16'd3);
        6:       write_reg(CFG_TEMPO_MS, TEMPO_W'($urandom_range(0, 6)));
        default: write_reg(CFG_TEMPO_MS, 16'd1);
      endcase
      mode    = TEMPO_W'($urandom);
      mode[0] = p[0];
      write_reg(CFG_ONE_SHOT, mode);
      send_word(KIND_START, IDX_W'($urandom), BYTE_W'($urandom), pick_gap());
      repeat (100) begin
        if ($urandom_range(0, 39) == 0) burst = !burst;
        if ($urandom_range(0, 149) == 0) wait_quiet();
        pick = $urandom_range(0, 99);
        if (pick < 68) begin
          send_word(KIND_TICK, IDX_W'($urandom), BYTE_W'($urandom), pick_gap());
        end else if (pick < 84) begin
          idx = IDX_W'($urandom);
          r   = $urandom_range(0, 99);
          if (!idx[0]) begin
            if (r < 60)      data = CHAR_ZERO + 8'($urandom_range(1, 2));
            else if (r < 92) data = CHAR_ZERO + 8'($urandom_range(3, 9));
            else if (r < 96) data = CHAR_ZERO;
            else             data = BYTE_W'($urandom);
          end else begin
            if (r < 85) data = note_chars.getc($urandom_range(0, note_chars.len() - 1));
            else        data = BYTE_W'($urandom);
          end
          send_word(KIND_WRITE, idx, data, pick_gap());
        end else if (pick < 88) begin
          send_word(KIND_WRITE, IDX_W'($urandom), BYTE_W'($urandom), pick_gap());
        end else if (pick < 95) begin
          send_word(KIND_START, IDX_W'($urandom), BYTE_W'($urandom), pick_gap());
        end else begin
          send_word(KIND_STOP, IDX_W'($urandom), BYTE_W'($urandom), pick_gap());
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin : run_tests
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    test_reset_tempo();
    test_load_melody();
    test_loop_play();
    test_end_marker();
    test_stop_mid_melody();
    test_tempo_extremes();
    test_random_phases();

    // Every word has been taken: wait for the last results and a little beyond.
    wait_quiet();
    if (fails == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/amsu_pkg.sv
rtl/amsu_ram.sv
rtl/amsu_step.sv
rtl/alarm_melody_sequencer_unit.sv
tb/tb_top.sv
